### rtl/core/mkte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: shared package
// Types, codes and the keypad character tables used by the controller and
// the datapath.
// ----------------------------------------------------------------------------
package mkte_pkg;

  // Buffer geometry
  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = 6;
  localparam int AGE_W        = 16;
  localparam int CAP_LIMIT    = (BUFFER_DEPTH < 63) ? BUFFER_DEPTH : 63;

  // Configuration register indexes
  localparam logic CFG_MAX_LENGTH = 1'b0;
  localparam logic CFG_TIMEOUT    = 1'b1;

  // Configuration reset values
  localparam logic [CNT_W-1:0] MAX_LENGTH_RST = 6'd63;
  localparam logic [AGE_W-1:0] TIMEOUT_RST    = 16'd1000;

  // Key codes (ASCII)
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;
  localparam logic [7:0] KEY_A    = 8'h41;
  localparam logic [7:0] KEY_B    = 8'h42;
  localparam logic [7:0] KEY_D    = 8'h44;

  typedef enum logic [1:0] {
    KIND_PRESS = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_CONTINUE  = 2'd0,
    ST_CONFIRMED = 2'd1,
    ST_CANCELLED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMMIT,
    S_APPLY,
    S_EMIT,
    S_PREP,
    S_STREAM
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the input transaction
    logic commit;  // commit phase: flush pending char, tick aging
    logic apply;   // apply phase: the key action itself
    logic prep;    // first buffer read of a confirm stream
    logic emit;    // single result cycle
    logic stream;  // one streamed buffer character
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic confirm_stream;  // confirm with a nonempty buffer
    logic last_char;       // current streamed char is the final one
  } dp_sts_t;

  // Character sets per digit key, unused slots zero
  localparam logic [7:0] KEY_SET [10][5] = '{
    '{8'h20, 8'h30, 8'h00, 8'h00, 8'h00},
    '{8'h2E, 8'h40, 8'h5F, 8'h2D, 8'h31},
    '{8'h61, 8'h62, 8'h63, 8'h32, 8'h00},
    '{8'h64, 8'h65, 8'h66, 8'h33, 8'h00},
    '{8'h67, 8'h68, 8'h69, 8'h34, 8'h00},
    '{8'h6A, 8'h6B, 8'h6C, 8'h35, 8'h00},
    '{8'h6D, 8'h6E, 8'h6F, 8'h36, 8'h00},
    '{8'h70, 8'h71, 8'h72, 8'h73, 8'h37},
    '{8'h74, 8'h75, 8'h76, 8'h38, 8'h00},
    '{8'h77, 8'h78, 8'h79, 8'h7A, 8'h39}
  };

  localparam logic [2:0] KEY_LEN [10] = '{
    3'd2, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd5
  };

  function automatic logic [2:0] key_len(input logic [3:0] digit);
    logic [2:0] len;
    len = 3'd1;
    if (digit <= 4'd9) begin
      len = KEY_LEN[digit];
    end
    return len;
  endfunction

  // Character at a tap position, upper case applied to letters
  function automatic logic [7:0] key_char(input logic [3:0] digit,
                                          input logic [2:0] pos,
                                          input logic       upper);
    logic [7:0] ch;
    ch = 8'h00;
    if (digit <= 4'd9 && pos < KEY_LEN[digit]) begin
      ch = KEY_SET[digit][pos];
      if (upper && ch >= 8'h61 && ch <= 8'h7A) begin
        ch = ch - 8'h20;
      end
    end
    return ch;
  endfunction

endpackage

### rtl/core/multitap_keypad_text_entry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry unit
// Phone-style multi-tap text entry over key presses, millisecond ticks and
// start commands, with a text buffer streamed out on confirm.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A key press, tick or
// start command gives one result after the commit, apply and emit states,
// and the unit takes the next item once it is back in idle. A confirm (#)
// with n > 0 buffered characters gives n results on consecutive cycles, the
// first after the commit, apply and prep states, and the unit is ready again
// after the last one: the buffer memory is read one character per cycle
// through its single registered read port. Each result is on the ports for
// one cycle with result_strobe_o high and must be captured then; there is no
// backpressure. Configuration writes are always ready and are meant to be
// issued while busy is low.
module multitap_keypad_text_entry_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 key_code_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [15:0]                cfg_data_i,
  output logic                       result_strobe_o,
  output logic [1:0]                 status_o,
  output logic [7:0]                 text_char_o,
  output logic                       text_valid_o,
  output logic                       last_o,
  output logic [mkte_pkg::CNT_W-1:0] text_length_o,
  output logic [7:0]                 pending_char_o,
  output logic                       pending_valid_o,
  output logic                       digit_mode_o,
  output logic                       upper_case_o
);
  import mkte_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  mkte_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .strobe_o (result_strobe_o)
  );

  // State, buffer and result fields
  mkte_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .key_code_i      (key_code_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status_o),
    .text_char_o     (text_char_o),
    .text_valid_o    (text_valid_o),
    .last_o          (last_o),
    .text_length_o   (text_length_o),
    .pending_char_o  (pending_char_o),
    .pending_valid_o (pending_valid_o),
    .digit_mode_o    (digit_mode_o),
    .upper_case_o    (upper_case_o)
  );

  // A taken transaction keeps the unit busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("unit not busy after taking a transaction");

  // Streamed characters only come with a confirm result
  a_text_on_confirm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_valid_o |-> (result_strobe_o && status_o == ST_CONFIRMED))
    else $error("text character outside a confirm result");

  // The final result of a transaction is followed by no other
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_o) |=> (!result_strobe_o && !busy))
    else $error("result after the final one of a transaction");

  // No pending character shown when nothing is cycling
  a_pending_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_valid_o |-> (pending_char_o == 8'h00))
    else $error("pending character without cycling");

endmodule

### rtl/core/mkte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: controller
// Sequences one transaction through commit, apply and result phases, and
// walks the buffer out one character per cycle on confirm.
// ----------------------------------------------------------------------------
module mkte_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mkte_pkg::dp_sts_t sts_i,
  output mkte_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              strobe_o
);
  import mkte_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.confirm_stream ? S_PREP : S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        strobe_o   = 1'b1;
        state_d    = S_IDLE;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_STREAM;
      end
      S_STREAM: begin
        cmd_o.stream = 1'b1;
        strobe_o     = 1'b1;
        if (sts_i.last_char) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/mkte_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-tap keypad text entry: datapath
// Configuration, entry state, text buffer memory and result fields.
// ----------------------------------------------------------------------------
module mkte_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mkte_pkg::dp_cmd_t          cmd_i,
  output mkte_pkg::dp_sts_t          sts_o,
  input  logic [1:0]                 kind_i,
  input  logic [7:0]                 key_code_i,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [15:0]                cfg_data_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 text_char_o,
  output logic                       text_valid_o,
  output logic                       last_o,
  output logic [mkte_pkg::CNT_W-1:0] text_length_o,
  output logic [7:0]                 pending_char_o,
  output logic                       pending_valid_o,
  output logic                       digit_mode_o,
  output logic                       upper_case_o
);
  import mkte_pkg::*;

  // Configuration
  logic [CNT_W-1:0] max_len_q;
  logic [AGE_W-1:0] timeout_q;

  // Captured transaction
  kind_e      kind_q;
  logic [7:0] key_q;

  // Entry state
  logic [CNT_W-1:0] count_q, count_d;
  logic [3:0]       pkey_q, pkey_d;
  logic [2:0]       tap_q, tap_d;
  logic             cyc_q, cyc_d;
  logic             case_q, case_d;
  logic             digit_q, digit_d;
  logic [AGE_W-1:0] age_q, age_d;
  status_e          status_q, status_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  // Text buffer
  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic             we;
  logic [7:0]       wdata;

  // Decode
  logic             is_digit, same_key, press_commit, room, tick_commit;
  logic [AGE_W-1:0] age_inc;
  logic [7:0]       pend_val;
  logic [2:0]       tap_inc;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LENGTH_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_LENGTH: max_len_q <= cfg_data_i[CNT_W-1:0];
        CFG_TIMEOUT:    timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_e'(kind_i);
      key_q  <= key_code_i;
    end
  end

  assign is_digit     = (key_q >= KEY_ZERO) && (key_q <= KEY_NINE);
  assign same_key     = cyc_q && is_digit && (key_q[3:0] == pkey_q);
  assign press_commit = (key_q == KEY_HASH) || (key_q == KEY_B) || (key_q == KEY_D) ||
                        (is_digit && (digit_q || !same_key));
  assign room         = (count_q < max_len_q) && (count_q < CNT_W'(CAP_LIMIT));
  assign age_inc      = (age_q == '1) ? age_q : age_q + AGE_W'(1);
  assign tick_commit  = age_inc >= timeout_q;
  assign pend_val     = cyc_q ? key_char(pkey_q, tap_q, case_q) : 8'h00;
  assign tap_inc      = tap_q + 3'd1;

  // Step logic: commit phase, then apply phase; stream steps the read index
  always_comb begin
    count_d  = count_q;
    pkey_d   = pkey_q;
    tap_d    = tap_q;
    cyc_d    = cyc_q;
    case_d   = case_q;
    digit_d  = digit_q;
    age_d    = age_q;
    status_d = status_q;
    idx_d    = idx_q;
    we       = 1'b0;
    wdata    = pend_val;

    if (cmd_i.commit) begin
      // timeout aging and commit ahead of the action
      if (cyc_q && ((kind_q == KIND_TICK && tick_commit) ||
                    (kind_q == KIND_PRESS && press_commit))) begin
        if (room) begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        cyc_d  = 1'b0;
        pkey_d = 4'd0;
        tap_d  = 3'd0;
      end
      if (kind_q == KIND_TICK && cyc_q) begin
        age_d = age_inc;
      end
    end

    if (cmd_i.apply) begin
      status_d = ST_CONTINUE;
      idx_d    = '0;
      unique case (kind_q)
        KIND_PRESS: begin
          priority if (key_q == KEY_HASH) begin
            status_d = ST_CONFIRMED;
          end else if (key_q == KEY_STAR) begin
            priority if (cyc_q) begin
              cyc_d  = 1'b0;
              pkey_d = 4'd0;
              tap_d  = 3'd0;
            end else if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end else begin
              status_d = ST_CANCELLED;
            end
          end else if (key_q == KEY_A) begin
            case_d = !case_q;
          end else if (key_q == KEY_D) begin
            digit_d = !digit_q;
          end else if (is_digit) begin
            priority if (digit_q) begin
              if (room) begin
                we      = 1'b1;
                wdata   = key_q;
                count_d = count_q + CNT_W'(1);
              end
            end else if (same_key) begin
              tap_d = (tap_inc >= key_len(pkey_q)) ? 3'd0 : tap_inc;
              age_d = '0;
            end else if (room) begin
              pkey_d = key_q[3:0];
              tap_d  = 3'd0;
              age_d  = '0;
              cyc_d  = 1'b1;
            end
          end
        end
        KIND_START: begin
          count_d = '0;
          pkey_d  = 4'd0;
          tap_d   = 3'd0;
          cyc_d   = 1'b0;
          case_d  = 1'b0;
          digit_d = 1'b0;
          age_d   = '0;
        end
        KIND_TICK, KIND_NONE: ;
        default: ;
      endcase
    end

    if (cmd_i.stream) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  // Entry state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pkey_q   <= 4'd0;
      tap_q    <= 3'd0;
      cyc_q    <= 1'b0;
      case_q   <= 1'b0;
      digit_q  <= 1'b0;
      age_q    <= '0;
      status_q <= ST_CONTINUE;
      idx_q    <= '0;
    end else begin
      count_q  <= count_d;
      pkey_q   <= pkey_d;
      tap_q    <= tap_d;
      cyc_q    <= cyc_d;
      case_q   <= case_d;
      digit_q  <= digit_d;
      age_q    <= age_d;
      status_q <= status_d;
      idx_q    <= idx_d;
    end
  end

  // Text buffer: one write port, one registered read port
  assign rd_addr = cmd_i.stream ? ADDR_W'(idx_q + CNT_W'(1)) : ADDR_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[ADDR_W'(count_q)] <= wdata;
    end
  end

  // Read port only runs while a confirm walks the buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep || cmd_i.stream) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Status to controller
  assign sts_o.confirm_stream = (kind_q == KIND_PRESS) && (key_q == KEY_HASH) &&
                                (count_q != '0);
  assign sts_o.last_char      = (idx_q + CNT_W'(1)) == count_q;

  // Result fields
  assign status_o        = status_q;
  assign text_char_o     = cmd_i.stream ? rd_data_q : 8'h00;
  assign text_valid_o    = cmd_i.stream;
  assign last_o          = cmd_i.emit || (cmd_i.stream && sts_o.last_char);
  assign text_length_o   = count_q;
  assign pending_char_o  = pend_val;
  assign pending_valid_o = cyc_q;
  assign digit_mode_o    = digit_q;
  assign upper_case_o    = case_q;

endmodule
